### design/pau_pkg.sv
// Package of the polynomial arithmetic unit: capacity, field widths,
// operation codes and sequencer states. No dependencies.

package pau_pkg;

  localparam int MaxTerms  = 16;
  localparam int ProdTerms = 2 * MaxTerms - 1;
  localparam int IdxW      = $clog2(MaxTerms);
  localparam int ProdIdxW  = IdxW + 1;
  localparam int LenW      = $clog2(MaxTerms + 1);
  localparam int DegW      = 5;
  localparam int LenExtW   = (LenW > DegW) ? LenW : DegW;

  localparam int OpW       = 3;
  localparam int IndexW    = 4;
  localparam int ValW      = 32;
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 40;

  typedef logic [ValW-1:0] coef_t;

  typedef enum logic [OpW-1:0] {
    OP_WR_ACC = 3'd0,
    OP_WR_OPD = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_EVAL   = 3'd5,
    OP_READ   = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ADDSUB,
    ST_MUL_INIT,
    ST_MUL_RUN,
    ST_MUL_DRAIN,
    ST_MUL_COPY,
    ST_EVAL_MUL,
    ST_EVAL_ADD,
    ST_READ,
    ST_TRIM,
    ST_DONE
  } state_e;

endpackage

### design/polynomial_arithmetic_unit.sv
// Polynomial arithmetic unit with one shared 32-bit multiplier under a small
// sequencer. Depends on pau_pkg.
//
// Usage: one command beat enters on the slave channel (op in tuser, the
// index, value and clear flag in tdata) and exactly one result beat leaves
// on the master channel. The slave side is ready only while the sequencer
// idles; the result sits in an output register, so a new command is taken
// while the previous result still waits for the receiver.
// Steps per operation (M = MaxTerms, La and Lb the accumulator and operand
// lengths); a new command can be taken once the result is in the output register:
//   write coefficient : store the value, then trim trailing zeros
//   add / subtract    : each operand coefficient in turn, then trimming
//   multiply          : La*Lb products through the single multiply-accumulate
//                       path (up to M*M = 256), a copy-back of the product terms
//                       and trimming; an empty side clears the accumulator
//   evaluate          : a multiply step and an add step per term
//   read / unused op  : one accumulator coefficient / a zero result
// Reset empties both polynomials and drops any pending result. While the
// receiver stalls, a finished result waits in the sequencer's final state
// and no further command is taken.

module polynomial_arithmetic_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [3:0] index, [35:4] value, [36] first, [39:37] zero
  input  logic [pau_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // [2:0] op
  input  logic [pau_pkg::OpW-1:0]        s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] result_value, [36:32] degree, [37] overflow, [39:38] zero
  output logic [pau_pkg::OutTdataW-1:0]  m_axis_tdata_o
);

  localparam int IdxW     = pau_pkg::IdxW;
  localparam int ProdIdxW = pau_pkg::ProdIdxW;
  localparam int LenW     = pau_pkg::LenW;
  localparam int LenExtW  = pau_pkg::LenExtW;
  localparam int DegW     = pau_pkg::DegW;

  pau_pkg::state_e state_q, state_d;
  pau_pkg::op_e    op_q, op_d, in_op;

  pau_pkg::coef_t acc_q  [pau_pkg::MaxTerms];
  pau_pkg::coef_t acc_d  [pau_pkg::MaxTerms];
  pau_pkg::coef_t opd_q  [pau_pkg::MaxTerms];
  pau_pkg::coef_t opd_d  [pau_pkg::MaxTerms];
  pau_pkg::coef_t prod_q [pau_pkg::ProdTerms];
  pau_pkg::coef_t prod_d [pau_pkg::ProdTerms];

  logic [LenW-1:0]          alen_q, alen_d, olen_q, olen_d;
  logic [pau_pkg::IndexW-1:0] idx_q, idx_d;
  pau_pkg::coef_t           val_q, val_d;
  logic                     first_q, first_d;
  logic                     tgt_q, tgt_d;
  logic [IdxW-1:0]          i_q, i_d, j_q, j_d;
  logic [ProdIdxW-1:0]      cnt_q, cnt_d;
  pau_pkg::coef_t           res_q, res_d;
  logic                     ovf_q, ovf_d;

  pau_pkg::coef_t           mul_q, mul_d;
  logic [ProdIdxW-1:0]      mul_addr_q, mul_addr_d;
  logic                     mul_vld_q, mul_vld_d;

  logic                     out_vld_q, out_vld_d;
  pau_pkg::coef_t           out_res_q, out_res_d;
  logic [DegW-1:0]          out_deg_q, out_deg_d;
  logic                     out_ovf_q, out_ovf_d;

  logic [IdxW-1:0]          acc_raddr, opd_raddr;
  logic [ProdIdxW-1:0]      prod_raddr;
  pau_pkg::coef_t           acc_rd, opd_rd, prod_rd;
  pau_pkg::coef_t           mul_a, mul_b, mul_p;
  logic                     in_acc;
  logic [LenW:0]            prod_len;
  logic [LenExtW-1:0]       deg_ext;

  assign in_op  = pau_pkg::op_e'(s_axis_tuser_i);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Single read port on each coefficient store; the sequencer picks the address.
  assign acc_rd  = acc_q[acc_raddr];
  assign opd_rd  = opd_q[opd_raddr];
  assign prod_rd = prod_q[prod_raddr];

  // The shared multiplier; only the low word of each product is kept.
  assign mul_p = mul_a * mul_b;

  assign prod_len = {1'b0, alen_q} + {1'b0, olen_q} - (LenW + 1)'(1);
  assign deg_ext  = LenExtW'(alen_q) - LenExtW'(1);

  assign s_axis_tready_o = (state_q == pau_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_ovf_q, out_deg_q, out_res_q};

  always_comb begin
    logic [LenW-1:0] base_len;
    logic [LenW-1:0] trim_len;
    pau_pkg::coef_t  trim_rd;

    state_d    = state_q;
    op_d       = op_q;
    acc_d      = acc_q;
    opd_d      = opd_q;
    prod_d     = prod_q;
    alen_d     = alen_q;
    olen_d     = olen_q;
    idx_d      = idx_q;
    val_d      = val_q;
    first_d    = first_q;
    tgt_d      = tgt_q;
    i_d        = i_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    ovf_d      = ovf_q;
    mul_d      = mul_q;
    mul_addr_d = mul_addr_q;
    mul_vld_d  = 1'b0;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_res_d  = out_res_q;
    out_deg_d  = out_deg_q;
    out_ovf_d  = out_ovf_q;
    acc_raddr  = '0;
    opd_raddr  = '0;
    prod_raddr = (state_q == pau_pkg::ST_MUL_COPY) ? cnt_q : mul_addr_q;
    mul_a      = res_q;
    mul_b      = val_q;
    base_len   = '0;
    trim_len   = tgt_q ? olen_q : alen_q;
    trim_rd    = '0;

    // Second stage of the multiply-accumulate pipeline.
    if (mul_vld_q) begin
      prod_d[mul_addr_q] = prod_rd + mul_q;
    end

    unique case (state_q)
      pau_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_d    = in_op;
          idx_d   = s_axis_tdata_i[3:0];
          val_d   = s_axis_tdata_i[35:4];
          first_d = s_axis_tdata_i[36];
          res_d   = '0;
          ovf_d   = 1'b0;
          tgt_d   = 1'b0;
          cnt_d   = '0;
          unique case (in_op)
            pau_pkg::OP_WR_ACC, pau_pkg::OP_WR_OPD: state_d = pau_pkg::ST_WRITE;
            pau_pkg::OP_ADD, pau_pkg::OP_SUB:       state_d = pau_pkg::ST_ADDSUB;
            pau_pkg::OP_MUL:                        state_d = pau_pkg::ST_MUL_INIT;
            pau_pkg::OP_EVAL: begin
              cnt_d   = ProdIdxW'(alen_q);
              state_d = pau_pkg::ST_EVAL_MUL;
            end
            pau_pkg::OP_READ:                       state_d = pau_pkg::ST_READ;
            default:                                state_d = pau_pkg::ST_DONE;
          endcase
        end
      end

      pau_pkg::ST_WRITE: begin
        tgt_d = (op_q == pau_pkg::OP_WR_OPD);
        if (op_q == pau_pkg::OP_WR_OPD) begin
          base_len = first_q ? '0 : olen_q;
          if (first_q) begin
            opd_d = '{default: '0};
          end
          olen_d = base_len;
          if (32'(idx_q) < pau_pkg::MaxTerms) begin
            opd_d[IdxW'(idx_q)] = val_q;
            if (LenW'(idx_q) + LenW'(1) > base_len) begin
              olen_d = LenW'(idx_q) + LenW'(1);
            end
          end
        end else begin
          base_len = first_q ? '0 : alen_q;
          if (first_q) begin
            acc_d = '{default: '0};
          end
          alen_d = base_len;
          if (32'(idx_q) < pau_pkg::MaxTerms) begin
            acc_d[IdxW'(idx_q)] = val_q;
            if (LenW'(idx_q) + LenW'(1) > base_len) begin
              alen_d = LenW'(idx_q) + LenW'(1);
            end
          end
        end
        state_d = pau_pkg::ST_TRIM;
      end

      pau_pkg::ST_ADDSUB: begin
        acc_raddr = IdxW'(cnt_q);
        opd_raddr = IdxW'(cnt_q);
        if (32'(cnt_q) < 32'(olen_q)) begin
          acc_d[IdxW'(cnt_q)] = (op_q == pau_pkg::OP_SUB) ? (acc_rd - opd_rd)
                                                          : (acc_rd + opd_rd);
          cnt_d = cnt_q + ProdIdxW'(1);
        end else begin
          if (olen_q > alen_q) begin
            alen_d = olen_q;
          end
          state_d = pau_pkg::ST_TRIM;
        end
      end

      pau_pkg::ST_MUL_INIT: begin
        if ((alen_q == '0) || (olen_q == '0)) begin
          acc_d   = '{default: '0};
          alen_d  = '0;
          state_d = pau_pkg::ST_DONE;
        end else begin
          prod_d  = '{default: '0};
          i_d     = '0;
          j_d     = '0;
          state_d = pau_pkg::ST_MUL_RUN;
        end
      end

      pau_pkg::ST_MUL_RUN: begin
        acc_raddr  = i_q;
        opd_raddr  = j_q;
        mul_a      = acc_rd;
        mul_b      = opd_rd;
        mul_d      = mul_p;
        mul_addr_d = ProdIdxW'(i_q) + ProdIdxW'(j_q);
        mul_vld_d  = 1'b1;
        if (LenW'(j_q) == olen_q - LenW'(1)) begin
          j_d = '0;
          if (LenW'(i_q) == alen_q - LenW'(1)) begin
            state_d = pau_pkg::ST_MUL_DRAIN;
          end else begin
            i_d = i_q + IdxW'(1);
          end
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end

      pau_pkg::ST_MUL_DRAIN: begin
        cnt_d   = '0;
        state_d = pau_pkg::ST_MUL_COPY;
      end

      pau_pkg::ST_MUL_COPY: begin
        // Low terms go back to the accumulator; nonzero dropped high terms raise the flag.
        if (32'(cnt_q) < pau_pkg::MaxTerms) begin
          acc_d[IdxW'(cnt_q)] = prod_rd;
        end else if (prod_rd != '0) begin
          ovf_d = 1'b1;
        end
        if (cnt_q == ProdIdxW'(pau_pkg::ProdTerms - 1)) begin
          if (32'(prod_len) > pau_pkg::MaxTerms) begin
            alen_d = LenW'(pau_pkg::MaxTerms);
          end else begin
            alen_d = prod_len[LenW-1:0];
          end
          state_d = pau_pkg::ST_TRIM;
        end else begin
          cnt_d = cnt_q + ProdIdxW'(1);
        end
      end

      pau_pkg::ST_EVAL_MUL: begin
        if (cnt_q == '0) begin
          state_d = pau_pkg::ST_DONE;
        end else begin
          mul_d   = mul_p;
          state_d = pau_pkg::ST_EVAL_ADD;
        end
      end

      pau_pkg::ST_EVAL_ADD: begin
        acc_raddr = IdxW'(cnt_q - ProdIdxW'(1));
        res_d     = mul_q + acc_rd;
        cnt_d     = cnt_q - ProdIdxW'(1);
        state_d   = pau_pkg::ST_EVAL_MUL;
      end

      pau_pkg::ST_READ: begin
        acc_raddr = IdxW'(idx_q);
        if (32'(idx_q) < 32'(alen_q)) begin
          res_d = acc_rd;
        end
        state_d = pau_pkg::ST_DONE;
      end

      pau_pkg::ST_TRIM: begin
        // Drop one trailing zero coefficient per cycle.
        acc_raddr = IdxW'(trim_len - LenW'(1));
        opd_raddr = IdxW'(trim_len - LenW'(1));
        trim_rd   = tgt_q ? opd_rd : acc_rd;
        if ((trim_len != '0) && (trim_rd == '0)) begin
          if (tgt_q) begin
            olen_d = olen_q - LenW'(1);
          end else begin
            alen_d = alen_q - LenW'(1);
          end
        end else begin
          state_d = pau_pkg::ST_DONE;
        end
      end

      pau_pkg::ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_res_d = res_q;
          out_deg_d = deg_ext[DegW-1:0];
          out_ovf_d = ovf_q;
          state_d   = pau_pkg::ST_IDLE;
        end
      end

      default: state_d = pau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pau_pkg::ST_IDLE;
      acc_q     <= '{default: '0};
      opd_q     <= '{default: '0};
      alen_q    <= '0;
      olen_q    <= '0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      opd_q     <= opd_d;
      alen_q    <= alen_d;
      olen_q    <= olen_d;
      mul_vld_q <= mul_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    prod_q     <= prod_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    first_q    <= first_d;
    tgt_q      <= tgt_d;
    i_q        <= i_d;
    j_q        <= j_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    ovf_q      <= ovf_d;
    mul_q      <= mul_d;
    mul_addr_q <= mul_addr_d;
    out_res_q  <= out_res_d;
    out_deg_q  <= out_deg_d;
    out_ovf_q  <= out_ovf_d;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(alen_q) <= pau_pkg::MaxTerms) && (32'(olen_q) <= pau_pkg::MaxTerms))
    else $error("polynomial length exceeds capacity");

  a_trimmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pau_pkg::ST_IDLE) && (alen_q != '0)
      |-> (acc_q[IdxW'(alen_q - LenW'(1))] != '0))
    else $error("accumulator has a trailing zero coefficient while idle");

  a_mac_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_vld_q |-> ($past(state_q) == pau_pkg::ST_MUL_RUN))
    else $error("product accumulate without a preceding multiply step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> (state_q != pau_pkg::ST_IDLE))
    else $error("sequencer idle right after a command beat");
`endif

endmodule
